// ----- rtl/ifhc_pkg.sv -----
// ============================================================================
// ifhc_pkg: shared types and constants for the ipv4 flow hash block
// Frame item, result item, front-to-back command, crc32c byte step.
// ============================================================================
`default_nettype none

package ifhc_pkg;

  // frame position counter width, saturating
  localparam int LENGTH_BITS = 16;
  typedef logic [LENGTH_BITS-1:0] pos_t;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // crc32c, reflected form
  localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;

  // header byte positions and sizes
  localparam int ETH_HDR_LEN    = 14;
  localparam int L4_HASH_BYTES  = 4;
  localparam int L4_MIN_EXTRA   = 8;
  localparam int POS_ETYPE_HI   = 12;
  localparam int POS_ETYPE_LO   = 13;
  localparam int POS_IHL        = 14;
  localparam int POS_FRAG_HI    = 20;
  localparam int POS_FRAG_LO    = 21;
  localparam int POS_PROTO      = 23;
  localparam int POS_ADDR_FIRST = 26;
  localparam int POS_ADDR_LAST  = 33;

  localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
  localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
  localparam logic [3:0] IHL_MIN       = 4'd5;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;

  // l4_kind codes
  localparam logic [1:0] L4_NONE   = 2'd0;
  localparam logic [1:0] L4_TCP    = 2'd1;
  localparam logic [1:0] L4_UDP    = 2'd2;
  localparam logic [1:0] L4_NOT_IP = 2'd3;

  // which value the result carries as its hash
  typedef enum logic [1:0] {
    SEL_VALUE,
    SEL_ADDR,
    SEL_FULL
  } hash_sel_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        frame_first;
    logic        frame_last;
    logic        nic_hash_valid;
    logic [31:0] nic_hash_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] flow_hash;
    logic        hash_written;
    logic        distribute;
    logic [1:0]  l4_kind;
  } out_item_t;

  // per-byte command from the classifier to the hash engine
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        upd_addr;
    logic        upd_full;
    logic        last;
    hash_sel_t   sel;
    logic [31:0] value;
    logic        hash_written;
    logic        distribute;
    logic [1:0]  l4_kind;
  } cmd_t;

  // one byte through the reflected crc32c
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ifhc_front.sv -----
// ============================================================================
// ifhc_front: frame parser and byte classifier
// Tracks the byte position, captures ethertype, ihl, fragment and protocol
// fields, and issues one hash command per accepted byte.
// ============================================================================
`default_nettype none

module ifhc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ifhc_pkg::in_item_t  in_data,
  output logic                push,
  output ifhc_pkg::cmd_t      push_cmd,
  input  logic                queue_full
);

  logic                bypass_r;
  ifhc_pkg::pos_t      pos_r, pos_nxt;
  logic                eth_ok_r, eth_ok_nxt;
  logic                ipv4_r, ipv4_nxt;
  logic [3:0]          hw_r, hw_nxt;
  logic [7:0]          proto_r, proto_nxt;
  logic                frag_r, frag_nxt;
  logic                nic_vld_r, nic_vld_nxt;
  logic [31:0]         nic_val_r, nic_val_nxt;

  // frame state as seen by this byte, before and after field capture
  ifhc_pkg::pos_t      pos;
  logic                eth_ok_b, ipv4_b, frag_b, nic_vld_b;
  logic [3:0]          hw_b;
  logic [7:0]          proto_b;
  logic [31:0]         nic_val_b;
  logic                eth_ok_n, ipv4_n, frag_n;
  logic [3:0]          hw_n;
  logic [7:0]          proto_n;
  ifhc_pkg::pos_t      l4_start, l4_end, l4_min;
  logic                eligible, in_addr, in_l4, use_l4, accept;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
    end else if (cfg_wr_en) begin
      bypass_r <= cfg_wr_data;
    end
  end

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept;

  // frame start restarts the state
  always_comb begin
    pos       = in_data.frame_first ? '0    : pos_r;
    eth_ok_b  = in_data.frame_first ? 1'b0  : eth_ok_r;
    ipv4_b    = in_data.frame_first ? 1'b0  : ipv4_r;
    hw_b      = in_data.frame_first ? 4'h0  : hw_r;
    proto_b   = in_data.frame_first ? 8'h00 : proto_r;
    frag_b    = in_data.frame_first ? 1'b0  : frag_r;
    nic_vld_b = in_data.frame_first ? in_data.nic_hash_valid : nic_vld_r;
    nic_val_b = in_data.frame_first ? in_data.nic_hash_value : nic_val_r;
  end

  // header field capture
  always_comb begin
    eth_ok_n = eth_ok_b;
    ipv4_n   = ipv4_b;
    hw_n     = hw_b;
    proto_n  = proto_b;
    frag_n   = frag_b;
    if (pos == ifhc_pkg::pos_t'(ifhc_pkg::POS_ETYPE_HI)) begin
      eth_ok_n = (in_data.frame_byte == ifhc_pkg::ETYPE_HI_IPV4);
    end else if (pos == ifhc_pkg::pos_t'(ifhc_pkg::POS_ETYPE_LO)) begin
      ipv4_n = eth_ok_b && (in_data.frame_byte == ifhc_pkg::ETYPE_LO_IPV4);
    end else if (pos == ifhc_pkg::pos_t'(ifhc_pkg::POS_IHL)) begin
      hw_n = in_data.frame_byte[3:0];
    end else if (pos == ifhc_pkg::pos_t'(ifhc_pkg::POS_FRAG_HI)) begin
      frag_n = frag_b || (|in_data.frame_byte[5:0]);
    end else if (pos == ifhc_pkg::pos_t'(ifhc_pkg::POS_FRAG_LO)) begin
      frag_n = frag_b || (|in_data.frame_byte);
    end else if (pos == ifhc_pkg::pos_t'(ifhc_pkg::POS_PROTO)) begin
      proto_n = in_data.frame_byte;
    end
  end

  // l4 window from the header length known before this byte
  assign l4_start = ifhc_pkg::pos_t'(ifhc_pkg::ETH_HDR_LEN) + ifhc_pkg::pos_t'({hw_b, 2'b00});
  assign l4_end   = l4_start + ifhc_pkg::pos_t'(ifhc_pkg::L4_HASH_BYTES);
  assign l4_min   = l4_start + ifhc_pkg::pos_t'(ifhc_pkg::L4_MIN_EXTRA);

  assign eligible = ipv4_n && (hw_n >= ifhc_pkg::IHL_MIN) && !frag_n &&
                    (proto_n == ifhc_pkg::PROTO_TCP || proto_n == ifhc_pkg::PROTO_UDP);
  assign in_addr  = ipv4_n && (pos >= ifhc_pkg::pos_t'(ifhc_pkg::POS_ADDR_FIRST)) &&
                    (pos <= ifhc_pkg::pos_t'(ifhc_pkg::POS_ADDR_LAST));
  assign in_l4    = eligible && (pos >= l4_start) && (pos < l4_end);
  assign use_l4   = eligible && (pos >= l4_min);

  // command build
  always_comb begin
    push_cmd          = '0;
    push_cmd.data     = in_data.frame_byte;
    push_cmd.first    = in_data.frame_first;
    push_cmd.upd_addr = in_addr;
    push_cmd.upd_full = in_addr || in_l4;
    push_cmd.last     = in_data.frame_last;
    push_cmd.sel      = ifhc_pkg::SEL_VALUE;
    if (bypass_r || nic_vld_b) begin
      push_cmd.value        = nic_vld_b ? nic_val_b : 32'h0;
      push_cmd.hash_written = 1'b0;
      push_cmd.distribute   = 1'b0;
      push_cmd.l4_kind      = ifhc_pkg::L4_NONE;
    end else if (!ipv4_n) begin
      push_cmd.value        = 32'h0;
      push_cmd.hash_written = 1'b0;
      push_cmd.distribute   = 1'b1;
      push_cmd.l4_kind      = ifhc_pkg::L4_NOT_IP;
    end else begin
      push_cmd.sel          = use_l4 ? ifhc_pkg::SEL_FULL : ifhc_pkg::SEL_ADDR;
      push_cmd.hash_written = 1'b1;
      push_cmd.distribute   = 1'b1;
      if (!use_l4) begin
        push_cmd.l4_kind = ifhc_pkg::L4_NONE;
      end else if (proto_n == ifhc_pkg::PROTO_TCP) begin
        push_cmd.l4_kind = ifhc_pkg::L4_TCP;
      end else begin
        push_cmd.l4_kind = ifhc_pkg::L4_UDP;
      end
    end
  end

  // next frame state
  always_comb begin
    pos_nxt     = pos_r;
    eth_ok_nxt  = eth_ok_r;
    ipv4_nxt    = ipv4_r;
    hw_nxt      = hw_r;
    proto_nxt   = proto_r;
    frag_nxt    = frag_r;
    nic_vld_nxt = nic_vld_r;
    nic_val_nxt = nic_val_r;
    if (accept) begin
      if (in_data.frame_last) begin
        pos_nxt     = '0;
        eth_ok_nxt  = 1'b0;
        ipv4_nxt    = 1'b0;
        hw_nxt      = 4'h0;
        proto_nxt   = 8'h00;
        frag_nxt    = 1'b0;
        nic_vld_nxt = 1'b0;
      end else begin
        pos_nxt     = (pos == '1) ? pos : pos + 1'b1;
        eth_ok_nxt  = eth_ok_n;
        ipv4_nxt    = ipv4_n;
        hw_nxt      = hw_n;
        proto_nxt   = proto_n;
        frag_nxt    = frag_n;
        nic_vld_nxt = nic_vld_b;
        nic_val_nxt = nic_val_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      eth_ok_r  <= 1'b0;
      ipv4_r    <= 1'b0;
      hw_r      <= 4'h0;
      proto_r   <= 8'h00;
      frag_r    <= 1'b0;
      nic_vld_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      eth_ok_r  <= eth_ok_nxt;
      ipv4_r    <= ipv4_nxt;
      hw_r      <= hw_nxt;
      proto_r   <= proto_nxt;
      frag_r    <= frag_nxt;
      nic_vld_r <= nic_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nic_val_r <= nic_val_nxt;
  end

  // a frame end always leaves a clean frame state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.frame_last |=> pos_r == '0 && !ipv4_r && !nic_vld_r)
    else $error("frame state not cleared after frame end");

endmodule

`default_nettype wire

// ----- rtl/ifhc_queue.sv -----
// ============================================================================
// ifhc_queue: command queue between classifier and hash engine
// Small fifo of hash commands; push and pop may happen in the same cycle.
// ============================================================================
`default_nettype none

module ifhc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ifhc_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output ifhc_pkg::cmd_t  head,
  output logic            empty
);

  ifhc_pkg::cmd_t                 entry_r [ifhc_pkg::QUEUE_DEPTH];
  logic [ifhc_pkg::QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [ifhc_pkg::QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [ifhc_pkg::QUEUE_AW:0]    count_r, count_nxt;
  logic                           do_push, do_pop;

  assign full    = (count_r == (ifhc_pkg::QUEUE_AW+1)'(ifhc_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (ifhc_pkg::QUEUE_AW+1)'(ifhc_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r - rd_ptr_r == count_r[ifhc_pkg::QUEUE_AW-1:0])
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ----- rtl/ifhc_back.sv -----
// ============================================================================
// ifhc_back: hash engine and result register
// Runs the address and full crc32c per command and forms the frame result
// on the last byte; the result register decouples the output stall.
// ============================================================================
`default_nettype none

module ifhc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ifhc_pkg::cmd_t       head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ifhc_pkg::out_item_t  out_data
);

  logic [31:0]          addr_crc_r, addr_crc_nxt;
  logic [31:0]          full_crc_r, full_crc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ifhc_pkg::out_item_t  out_data_r, out_data_nxt;
  logic [31:0]          addr_base, full_base;
  logic [31:0]          addr_step, full_step, addr_new, full_new;
  logic                 out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = !empty && (!head.last || out_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a frame start restarts both running sums
  assign addr_base = head.first ? 32'h0 : addr_crc_r;
  assign full_base = head.first ? 32'h0 : full_crc_r;

  // crc byte step for both running sums
  assign addr_step = ifhc_pkg::crc32c_byte(addr_base, head.data);
  assign full_step = ifhc_pkg::crc32c_byte(full_base, head.data);
  assign addr_new  = head.upd_addr ? addr_step : addr_base;
  assign full_new  = head.upd_full ? full_step : full_base;

  // crc state and result load
  always_comb begin
    addr_crc_nxt  = addr_crc_r;
    full_crc_nxt  = full_crc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop) begin
      if (head.last) begin
        addr_crc_nxt              = 32'h0;
        full_crc_nxt              = 32'h0;
        out_valid_nxt             = 1'b1;
        out_data_nxt.hash_written = head.hash_written;
        out_data_nxt.distribute   = head.distribute;
        out_data_nxt.l4_kind      = head.l4_kind;
        case (head.sel)
          ifhc_pkg::SEL_ADDR: out_data_nxt.flow_hash = addr_new;
          ifhc_pkg::SEL_FULL: out_data_nxt.flow_hash = full_new;
          default:            out_data_nxt.flow_hash = head.value;
        endcase
      end else begin
        addr_crc_nxt = addr_new;
        full_crc_nxt = full_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_crc_r  <= 32'h0;
      full_crc_r  <= 32'h0;
      out_valid_r <= 1'b0;
    end else begin
      addr_crc_r  <= addr_crc_nxt;
      full_crc_r  <= full_crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.last |=> addr_crc_r == 32'h0 && full_crc_r == 32'h0)
    else $error("crc not restarted after frame end");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("pending result lost under stall");

endmodule

`default_nettype wire

// ----- rtl/ipv4_flow_hash_crc32c.sv -----
// ============================================================================
// ipv4_flow_hash_crc32c: ipv4 flow hash over addresses and l4 ports
// Byte-wide frame in, one result per frame with crc32c hash and l4 kind.
// ============================================================================
//
//   channel | direction | handshake           | transfer payload
//   --------+-----------+---------------------+-------------------------
//   in_     | input     | in_valid / in_stall | in_item_t, one frame byte
//   out_    | output    | out_valid/out_stall | out_item_t, one per frame
//   cfg_    | input     | cfg_wr_en           | hash_bypass bit
//
// one frame byte per clock sustained while in_stall is low, independent of frame length
// a result is loaded into the output register when the frame's last command pops from the queue
// a 4-entry command queue lets the parser keep taking bytes while a result
// waits under out_stall; in_stall rises only once that queue is full
// synchronous active-low reset clears frame state, crc state and bypass
//
`default_nettype none

module ipv4_flow_hash_crc32c (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ifhc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ifhc_pkg::out_item_t  out_data
);

  logic            push, queue_full, pop, queue_empty;
  ifhc_pkg::cmd_t  push_cmd, head_cmd;

  // parser and classifier
  ifhc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .push        (push),
    .push_cmd    (push_cmd),
    .queue_full  (queue_full)
  );

  // command queue
  ifhc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .head     (head_cmd),
    .empty    (queue_empty)
  );

  // hash engine
  ifhc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_cmd),
    .empty     (queue_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/ifhc_flow_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// ifhc_flow_checker: result predictor and scoreboard for the ipv4 flow hash
// Watches the frame, result and register ports of the block. Every accepted
// frame byte steps an independent model of the parser and crc32c state; each
// frame end queues the hash result it must produce. Every result transfer is
// compared field by field against the oldest queued result.
// ============================================================================

module ifhc_flow_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ifhc_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ifhc_pkg::out_item_t  out_data,
  output int                   fail_count,
  output int                   results_pending,
  output int                   results_checked
);

  localparam logic [31:0] CASTAGNOLI_REFLECTED = 32'h82F6_3B78;

  // register copy and per-frame parser state
  logic           bypass_on;
  ifhc_pkg::pos_t byte_count;
  logic [31:0]    addr_crc;
  logic [31:0]    flow_crc;
  logic           etype_hi_match;
  logic           ipv4_frame;
  logic [3:0]     ihl;
  logic [7:0]     proto;
  logic           frag;
  logic           nic_present;
  logic [31:0]    nic_value;

  ifhc_pkg::out_item_t hash_results_due[$];

  // bitwise reflected crc32c, one data bit at a time
  function automatic logic [31:0] crc32c_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CASTAGNOLI_REFLECTED;
    end
    return c;
  endfunction

  function automatic void clear_frame();
    byte_count     = '0;
    addr_crc       = '0;
    flow_crc       = '0;
    etype_hi_match = 1'b0;
    ipv4_frame     = 1'b0;
    ihl            = '0;
    proto          = '0;
    frag           = 1'b0;
    nic_present    = 1'b0;
    nic_value      = '0;
  endfunction

  // advance the parser by one frame byte, queue a result on frame end
  task automatic hash_frame_byte(input ifhc_pkg::in_item_t item);
    int unsigned         pos;
    int unsigned         l4_base;
    logic                l4_ok;
    logic                use_l4;
    ifhc_pkg::out_item_t res;
    if (item.frame_first) begin
      clear_frame();
      if (item.nic_hash_valid) begin
        nic_present = 1'b1;
        nic_value   = item.nic_hash_value;
      end
    end
    pos     = byte_count;
    l4_base = ifhc_pkg::ETH_HDR_LEN + 4 * ihl;

    // header field capture
    case (pos)
      ifhc_pkg::POS_ETYPE_HI:
        etype_hi_match = (item.frame_byte == ifhc_pkg::ETYPE_HI_IPV4);
      ifhc_pkg::POS_ETYPE_LO:
        ipv4_frame = etype_hi_match && (item.frame_byte == ifhc_pkg::ETYPE_LO_IPV4);
      ifhc_pkg::POS_IHL:      ihl = item.frame_byte[3:0];
      ifhc_pkg::POS_FRAG_HI:  frag = frag || (item.frame_byte[5:0] != 6'd0);
      ifhc_pkg::POS_FRAG_LO:  frag = frag || (item.frame_byte != 8'd0);
      ifhc_pkg::POS_PROTO:    proto = item.frame_byte;
      default: ;
    endcase

    l4_ok = ipv4_frame && (ihl >= ifhc_pkg::IHL_MIN) && !frag &&
            (proto == ifhc_pkg::PROTO_TCP || proto == ifhc_pkg::PROTO_UDP);

    // address bytes feed both crcs, l4 port bytes only the full one
    if (ipv4_frame && pos >= ifhc_pkg::POS_ADDR_FIRST && pos <= ifhc_pkg::POS_ADDR_LAST) begin
      addr_crc = crc32c_next(addr_crc, item.frame_byte);
      flow_crc = crc32c_next(flow_crc, item.frame_byte);
    end else if (l4_ok && pos >= l4_base && pos < l4_base + ifhc_pkg::L4_HASH_BYTES) begin
      flow_crc = crc32c_next(flow_crc, item.frame_byte);
    end

    if (byte_count != '1) byte_count = byte_count + 1'b1;

    if (item.frame_last) begin
      if (bypass_on || nic_present) begin
        res.flow_hash    = nic_present ? nic_value : 32'd0;
        res.hash_written = 1'b0;
        res.distribute   = 1'b0;
        res.l4_kind      = ifhc_pkg::L4_NONE;
      end else if (!ipv4_frame) begin
        res.flow_hash    = 32'd0;
        res.hash_written = 1'b0;
        res.distribute   = 1'b1;
        res.l4_kind      = ifhc_pkg::L4_NOT_IP;
      end else begin
        use_l4           = l4_ok && (pos >= l4_base + ifhc_pkg::L4_MIN_EXTRA);
        res.flow_hash    = use_l4 ? flow_crc : addr_crc;
        res.hash_written = 1'b1;
        res.distribute   = 1'b1;
        res.l4_kind      = !use_l4 ? ifhc_pkg::L4_NONE :
                           (proto == ifhc_pkg::PROTO_TCP) ? ifhc_pkg::L4_TCP :
                           ifhc_pkg::L4_UDP;
      end
      hash_results_due.push_back(res);
      clear_frame();
    end
  endtask

  // compare one result transfer with the oldest queued result
  task automatic check_result(input ifhc_pkg::out_item_t got);
    ifhc_pkg::out_item_t want;
    if (hash_results_due.size() == 0) begin
      $error("result transfer with no frame end pending: flow_hash %h", got.flow_hash);
      fail_count++;
      return;
    end
    want = hash_results_due.pop_front();
    results_checked++;
    if (got.flow_hash !== want.flow_hash) begin
      $error("flow_hash: expected %h, actual %h", want.flow_hash, got.flow_hash);
      fail_count++;
    end
    if (got.hash_written !== want.hash_written) begin
      $error("hash_written: expected %b, actual %b", want.hash_written, got.hash_written);
      fail_count++;
    end
    if (got.distribute !== want.distribute) begin
      $error("distribute: expected %b, actual %b", want.distribute, got.distribute);
      fail_count++;
    end
    if (got.l4_kind !== want.l4_kind) begin
      $error("l4_kind: expected %0d, actual %0d", want.l4_kind, got.l4_kind);
      fail_count++;
    end
  endtask

  // sample all ports at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      bypass_on = 1'b0;
      clear_frame();
      hash_results_due.delete();
      fail_count      = 0;
      results_checked = 0;
    end else begin
      if (cfg_wr_en) bypass_on = cfg_wr_data;
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) hash_frame_byte(in_data);
    end
    results_pending = hash_results_due.size();
  end

endmodule

// ----- tb/ipv4_flow_hash_crc32c_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// ipv4_flow_hash_crc32c_test: frame stimulus for the ipv4 flow hash block
// Sends directed frames covering header corner cases and both bypass
// settings, then a random mix of well-formed and broken frames with random
// idle on both channels and one long result hold.
// ============================================================================

module ipv4_flow_hash_crc32c_test;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic                cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  ifhc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  ifhc_pkg::out_item_t out_data;

  int        check_failures;
  int        results_pending;
  int        results_checked;

  logic [7:0] frame_buf[$];
  bit         sender_gaps;
  bit         held_off;
  int         bytes_sent;
  int         frames_sent;

  ipv4_flow_hash_crc32c DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  ifhc_flow_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (check_failures),
    .results_pending (results_pending),
    .results_checked (results_checked)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: random stall, one long hold, a quiet stretch
  initial begin
    out_stall = 1'b0;
    held_off  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_checked >= 6) begin
        held_off  = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end
      if (results_checked >= 12 && results_checked < 20) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 16);
    end
  end

  // one frame byte transfer, with an optional idle cycle in front
  task automatic send_byte(input ifhc_pkg::in_item_t item);
    if (sender_gaps && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic nic_v, input logic [31:0] nic_val,
                            input bit with_first, input bit with_last);
    ifhc_pkg::in_item_t item;
    foreach (frame_buf[i]) begin
      item.frame_byte     = frame_buf[i];
      item.frame_first    = with_first && (i == 0);
      item.frame_last     = with_last && (i == frame_buf.size() - 1);
      item.nic_hash_valid = (i == 0) ? nic_v : 1'($urandom);
      item.nic_hash_value = (i == 0 && nic_v) ? nic_val : $urandom;
      send_byte(item);
    end
    frames_sent++;
  endtask

  // random frame body with ipv4 header fields placed where the frame reaches
  task automatic build_ipv4(input logic [7:0] proto_num, input logic [3:0] hdr_words,
                            input logic [7:0] frag_hi, input logic [7:0] frag_lo,
                            input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    if (len > ifhc_pkg::POS_ETYPE_HI)
      frame_buf[ifhc_pkg::POS_ETYPE_HI] = ifhc_pkg::ETYPE_HI_IPV4;
    if (len > ifhc_pkg::POS_ETYPE_LO)
      frame_buf[ifhc_pkg::POS_ETYPE_LO] = ifhc_pkg::ETYPE_LO_IPV4;
    if (len > ifhc_pkg::POS_IHL)     frame_buf[ifhc_pkg::POS_IHL] = {4'($urandom), hdr_words};
    if (len > ifhc_pkg::POS_FRAG_HI) frame_buf[ifhc_pkg::POS_FRAG_HI] = frag_hi;
    if (len > ifhc_pkg::POS_FRAG_LO) frame_buf[ifhc_pkg::POS_FRAG_LO] = frag_lo;
    if (len > ifhc_pkg::POS_PROTO)   frame_buf[ifhc_pkg::POS_PROTO]   = proto_num;
  endtask

  // stop offering and wait until every queued result has left the block
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_bypass(input logic value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // frame stimulus and verdict
  initial begin
    int          kind;
    int          n;
    logic [3:0]  hw;
    logic [7:0]  proto_pick;
    logic [7:0]  tcp;
    logic [7:0]  udp;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    sender_gaps = 1'b1;
    bytes_sent  = 0;
    frames_sent = 0;
    tcp         = ifhc_pkg::PROTO_TCP;
    udp         = ifhc_pkg::PROTO_UDP;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: l4 length threshold at both ihl extremes, no sender idle
    write_bypass(1'b0);
    sender_gaps = 1'b0;
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 42);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 43);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(udp, 4'd15, 8'h00, 8'h00, 83); send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(udp, 4'd15, 8'h00, 8'h00, 82); send_frame(1'b0, 32'd0, 1, 1);
    sender_gaps = 1'b1;
    // ihl below five
    build_ipv4(tcp, 4'd4, 8'h00, 8'h00, 43);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(tcp, 4'd0, 8'h00, 8'h00, 43);  send_frame(1'b0, 32'd0, 1, 1);
    // more-fragments, dont-fragment and reserved bits, offset low and high bits
    build_ipv4(tcp, 4'd5, 8'h20, 8'h00, 43);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(udp, 4'd5, 8'hC0, 8'h00, 43);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h01, 43);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(udp, 4'd5, 8'h1F, 8'h00, 43);  send_frame(1'b0, 32'd0, 1, 1);
    // other protocol
    build_ipv4(8'd1, 4'd5, 8'h00, 8'h00, 43); send_frame(1'b0, 32'd0, 1, 1);
    // short frames: partial addresses, no ethertype, single byte
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 30);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 13);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 1);   send_frame(1'b0, 32'd0, 1, 1);
    // not ipv4
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 20);
    frame_buf[ifhc_pkg::POS_ETYPE_HI] = 8'h86;
    frame_buf[ifhc_pkg::POS_ETYPE_LO] = 8'hDD;
    send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 20);
    frame_buf[ifhc_pkg::POS_ETYPE_LO] = 8'h06;
    send_frame(1'b0, 32'd0, 1, 1);
    frame_buf.delete();
    repeat (20) frame_buf.push_back(8'hFF);
    send_frame(1'b0, 32'd0, 1, 1);
    frame_buf.delete();
    repeat (20) frame_buf.push_back(8'h00);
    send_frame(1'b0, 32'd0, 1, 1);
    // nic hash present, both extremes
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 20);  send_frame(1'b1, 32'hFFFF_FFFF, 1, 1);
    build_ipv4(udp, 4'd5, 8'h00, 8'h00, 20);  send_frame(1'b1, 32'h0000_0000, 1, 1);
    // restart in mid-frame, then a frame with no start flag
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 28);  send_frame(1'b1, 32'h1234_5678, 1, 0);
    build_ipv4(udp, 4'd6, 8'h00, 8'h00, 47);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 43);  send_frame(1'b0, 32'd0, 0, 1);

    // bypass on
    write_bypass(1'b1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 20);  send_frame(1'b0, 32'd0, 1, 1);
    build_ipv4(udp, 4'd5, 8'h00, 8'h00, 20);  send_frame(1'b1, $urandom, 1, 1);
    build_ipv4(tcp, 4'd5, 8'h00, 8'h00, 20);
    frame_buf[ifhc_pkg::POS_ETYPE_HI] = 8'h81;
    send_frame(1'b0, 32'd0, 1, 1);
    write_bypass(1'b0);

    // random frames, mostly well formed
    n = 0;
    while (n < 6) begin
      kind       = $urandom_range(99);
      hw         = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      proto_pick = $urandom_range(1) ? tcp : udp;
      if (kind < 55) begin
        build_ipv4(proto_pick, hw, {2'($urandom), 6'd0}, 8'h00,
                   ifhc_pkg::ETH_HDR_LEN + 4 * hw + $urandom_range(6, 30));
        send_frame(1'b0, 32'd0, 1, 1);
      end else if (kind < 62) begin
        if ($urandom_range(1))
          build_ipv4(proto_pick, hw, {2'($urandom), 6'($urandom_range(1, 63))}, 8'($urandom),
                     ifhc_pkg::ETH_HDR_LEN + 4 * hw + $urandom_range(6, 30));
        else
          build_ipv4(proto_pick, hw, {2'($urandom), 6'd0}, 8'($urandom_range(1, 255)),
                     ifhc_pkg::ETH_HDR_LEN + 4 * hw + $urandom_range(6, 30));
        send_frame(1'b0, 32'd0, 1, 1);
      end else if (kind < 68) begin
        if ($urandom_range(1)) build_ipv4(8'($urandom), hw, 8'h00, 8'h00, $urandom_range(34, 90));
        else build_ipv4(proto_pick, 4'($urandom_range(0, 4)), 8'h00, 8'h00,
                        $urandom_range(34, 90));
        send_frame(1'b0, 32'd0, 1, 1);
      end else if (kind < 76) begin
        build_ipv4(proto_pick, hw, 8'h00, 8'h00, $urandom_range(1, 42));
        send_frame(1'b0, 32'd0, 1, 1);
      end else if (kind < 84) begin
        build_ipv4(proto_pick, hw, 8'h00, 8'h00, $urandom_range(14, 80));
        if ($urandom_range(1)) frame_buf[ifhc_pkg::POS_ETYPE_HI] ^= 8'($urandom_range(1, 255));
        else frame_buf[ifhc_pkg::POS_ETYPE_LO] ^= 8'($urandom_range(1, 255));
        send_frame(1'b0, 32'd0, 1, 1);
      end else if (kind < 90) begin
        build_ipv4(proto_pick, hw, 8'h00, 8'h00,
                   ifhc_pkg::ETH_HDR_LEN + 4 * hw + $urandom_range(6, 30));
        send_frame(1'b1, $urandom, 1, 1);
      end else if (kind < 95) begin
        build_ipv4(proto_pick, hw, 8'h00, 8'h00, $urandom_range(2, 50));
        send_frame(1'($urandom), $urandom, 1, 0);
        build_ipv4(proto_pick, hw, 8'h00, 8'h00,
                   ifhc_pkg::ETH_HDR_LEN + 4 * hw + $urandom_range(6, 30));
        send_frame(1'b0, 32'd0, 1, 1);
      end else begin
        build_ipv4(proto_pick, hw, 8'h00, 8'h00,
                   ifhc_pkg::ETH_HDR_LEN + 4 * hw + $urandom_range(6, 30));
        send_frame(1'b0, 32'd0, 0, 1);
      end
      n++;
    end

    // drain and verdict
    wait_drained();
    repeat (20) @(negedge clk);
    $display("covered %0d frames in %0d byte transfers, %0d results compared,",
             frames_sent, bytes_sent, results_checked);
    $display("bypass on and off, nic hash, fragments, restarts and short frames");
    if (check_failures == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (results_pending != 0) $error("%0d results never arrived", results_pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
